[hw/rtl/qcsv_pkg.sv]
package qcsv_pkg;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_CLOSED = 3'd1,
        MODE_QUOTE  = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_SKIP   = 3'd4
    } t_mode;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_N      = 8'd110;
    localparam logic [7:0] CH_R      = 8'd114;
    localparam logic [7:0] CH_NUL    = 8'd0;

    typedef struct packed {
        logic [7:0] char_value;
        logic       char_valid;
        logic       field_end;
        logic       row_end;
        logic       quote_error;
    } t_result;

endpackage

[hw/rtl/qcsv_if.sv]
interface qcsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface qcsv_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_value;
    logic       char_valid;
    logic       field_end;
    logic       row_end;
    logic       quote_error;

    modport source (output valid, output char_value, output char_valid, output field_end,
                    output row_end, output quote_error, input ready);
    modport sink   (input valid, input char_value, input char_valid, input field_end,
                    input row_end, input quote_error, output ready);
endinterface

[hw/rtl/qcsv_step.sv]
module qcsv_step (
    input  qcsv_pkg::t_mode   i_mode,
    input  logic              i_line_empty,
    input  logic [7:0]        i_byte,
    output qcsv_pkg::t_mode   o_mode,
    output logic              o_line_empty,
    output logic              o_emit,
    output qcsv_pkg::t_result o_res
);

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] v;
        v = qcsv_pkg::CH_NUL;
        if (b == qcsv_pkg::CH_N) begin
            v = qcsv_pkg::CH_NL;
        end else if (b == qcsv_pkg::CH_R) begin
            v = qcsv_pkg::CH_CR;
        end else if (b == qcsv_pkg::CH_QUOTE || b == qcsv_pkg::CH_BSLASH) begin
            v = b;
        end
        return v;
    endfunction

    logic is_nl;
    assign is_nl = (i_byte == qcsv_pkg::CH_NL);

    // next state
    always_comb begin
        o_mode       = i_mode;
        o_line_empty = 1'b0;
        if (is_nl) begin
            o_mode       = qcsv_pkg::MODE_START;
            o_line_empty = 1'b1;
        end else begin
            unique case (i_mode)
                qcsv_pkg::MODE_QUOTE: begin
                    if (i_byte == qcsv_pkg::CH_QUOTE) begin
                        o_mode = qcsv_pkg::MODE_CLOSED;
                    end else if (i_byte == qcsv_pkg::CH_BSLASH) begin
                        o_mode = qcsv_pkg::MODE_ESCAPE;
                    end
                end
                qcsv_pkg::MODE_ESCAPE: begin
                    o_mode = qcsv_pkg::MODE_QUOTE;
                end
                qcsv_pkg::MODE_SKIP: begin
                    o_mode = qcsv_pkg::MODE_SKIP;
                end
                default: begin
                    // field start, after closing quote, or an unused code
                    if (i_byte == qcsv_pkg::CH_CR) begin
                        o_mode = qcsv_pkg::MODE_SKIP;
                    end else if (i_byte == qcsv_pkg::CH_QUOTE) begin
                        o_mode = qcsv_pkg::MODE_QUOTE;
                    end else if (i_byte == qcsv_pkg::CH_COMMA) begin
                        o_mode = qcsv_pkg::MODE_START;
                    end else if (i_mode == qcsv_pkg::MODE_CLOSED) begin
                        o_mode = qcsv_pkg::MODE_CLOSED;
                    end else begin
                        o_mode = qcsv_pkg::MODE_START;
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_emit = 1'b0;
        o_res  = '0;
        if (is_nl) begin
            if (i_mode == qcsv_pkg::MODE_QUOTE || i_mode == qcsv_pkg::MODE_ESCAPE) begin
                o_emit            = 1'b1;
                o_res.field_end   = 1'b1;
                o_res.row_end     = 1'b1;
                o_res.quote_error = 1'b1;
            end else if (!i_line_empty) begin
                o_emit        = 1'b1;
                o_res.row_end = 1'b1;
            end
        end else begin
            unique case (i_mode)
                qcsv_pkg::MODE_QUOTE: begin
                    if (i_byte == qcsv_pkg::CH_QUOTE) begin
                        o_emit          = 1'b1;
                        o_res.field_end = 1'b1;
                    end else if (i_byte != qcsv_pkg::CH_BSLASH) begin
                        o_emit           = 1'b1;
                        o_res.char_value = i_byte;
                        o_res.char_valid = 1'b1;
                    end
                end
                qcsv_pkg::MODE_ESCAPE: begin
                    o_emit           = 1'b1;
                    o_res.char_value = unescape(i_byte);
                    o_res.char_valid = 1'b1;
                end
                qcsv_pkg::MODE_SKIP: begin
                    o_emit = 1'b0;
                end
                default: begin
                    // comma after a closing quote is swallowed
                    if (i_byte == qcsv_pkg::CH_COMMA && i_mode != qcsv_pkg::MODE_CLOSED) begin
                        o_emit          = 1'b1;
                        o_res.field_end = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

[hw/rtl/quoted_csv_field_parser_core.sv]
// Channel  Dir  Modport        Payload
// i_in     in   qcsv_byte_if   byte_in[7:0]
// o_out    out  qcsv_res_if    char_value[7:0], char_valid, field_end, row_end, quote_error
//
// One byte per cycle sustained while the result side is not stalled. A byte passes the input
// register, then the parse step into the result register.
// The parse mode and blank-line flag advance as a byte leaves the input register.
// Synchronous active-low reset clears both valids and the parse state.
// A stalled result holds the input register, whether or not the byte in it gives a result.
module quoted_csv_field_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qcsv_byte_if.sink  i_in,
    qcsv_res_if.source o_out
);

    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    qcsv_pkg::t_mode   r_mode;
    logic              r_line_empty;
    logic              r_out_valid;
    qcsv_pkg::t_result r_out;

    qcsv_pkg::t_mode   n_mode;
    logic              n_line_empty;
    logic              step_emit;
    qcsv_pkg::t_result step_res;
    logic              s1_adv;

    qcsv_step u_step (
        .i_mode       (r_mode),
        .i_line_empty (r_line_empty),
        .i_byte       (r_s1_byte),
        .o_mode       (n_mode),
        .o_line_empty (n_line_empty),
        .o_emit       (step_emit),
        .o_res        (step_res)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_mode       <= qcsv_pkg::MODE_START;
            r_line_empty <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_mode       <= n_mode;
                r_line_empty <= n_line_empty;
            end
            if (s1_adv && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.byte_in;
        end
        if (s1_adv && step_emit) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_value  = r_out.char_value;
    assign o_out.char_valid  = r_out.char_valid;
    assign o_out.field_end   = r_out.field_end;
    assign o_out.row_end     = r_out.row_end;
    assign o_out.quote_error = r_out.quote_error;

    // a quote error always closes both field and row
    a_err_closes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.quote_error) |-> (o_out.field_end && o_out.row_end))
        else $error("quote error without field and row end");

    // a held byte in the input register is not lost or altered
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_byte)))
        else $error("input register dropped a stalled beat");

    // after a row end the parser is back at field start on a blank line
    a_row_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && step_emit && step_res.row_end)
            |=> (r_mode == qcsv_pkg::MODE_START && r_line_empty))
        else $error("parse state not cleared after row end");

    // the state only moves when a byte is consumed
    a_mode_still : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> ($stable(r_mode) && $stable(r_line_empty)))
        else $error("parse state changed without a beat");

endmodule

[dv/tb_quoted_csv_field_parser_core.sv]
`timescale 1ns / 100ps

module tb_quoted_csv_field_parser_core;

    class csv_scoreboard;
        qcsv_pkg::t_mode   mode;
        bit                line_empty;
        qcsv_pkg::t_result pending[$];
        int                n_fail;
        int                n_bytes;

        function new();
            mode       = qcsv_pkg::MODE_START;
            line_empty = 1'b1;
            n_fail     = 0;
            n_bytes    = 0;
        endfunction

        function logic [7:0] unescape(logic [7:0] b);
            case (b)
                qcsv_pkg::CH_N:      return qcsv_pkg::CH_NL;
                qcsv_pkg::CH_R:      return qcsv_pkg::CH_CR;
                qcsv_pkg::CH_QUOTE:  return qcsv_pkg::CH_QUOTE;
                qcsv_pkg::CH_BSLASH: return qcsv_pkg::CH_BSLASH;
                default:             return qcsv_pkg::CH_NUL;
            endcase
        endfunction

        // advance the parse state by one accepted byte, queue any result
        function void note_byte(logic [7:0] b);
            qcsv_pkg::t_result r;
            bit                has;
            qcsv_pkg::t_mode   prev;
            bit                was_empty;
            r         = '0;
            has       = 1'b0;
            prev      = mode;
            was_empty = line_empty;
            if (b == qcsv_pkg::CH_NL) begin
                mode       = qcsv_pkg::MODE_START;
                line_empty = 1'b1;
                if (prev == qcsv_pkg::MODE_QUOTE || prev == qcsv_pkg::MODE_ESCAPE) begin
                    r.field_end   = 1'b1;
                    r.row_end     = 1'b1;
                    r.quote_error = 1'b1;
                    has           = 1'b1;
                end else if (!was_empty) begin
                    r.row_end = 1'b1;
                    has       = 1'b1;
                end
            end else begin
                line_empty = 1'b0;
                case (prev)
                    qcsv_pkg::MODE_QUOTE: begin
                        if (b == qcsv_pkg::CH_QUOTE) begin
                            mode        = qcsv_pkg::MODE_CLOSED;
                            r.field_end = 1'b1;
                            has         = 1'b1;
                        end else if (b == qcsv_pkg::CH_BSLASH) begin
                            mode = qcsv_pkg::MODE_ESCAPE;
                        end else begin
                            r.char_value = b;
                            r.char_valid = 1'b1;
                            has          = 1'b1;
                        end
                    end
                    qcsv_pkg::MODE_ESCAPE: begin
                        mode         = qcsv_pkg::MODE_QUOTE;
                        r.char_value = unescape(b);
                        r.char_valid = 1'b1;
                        has          = 1'b1;
                    end
                    qcsv_pkg::MODE_SKIP: ;
                    default: begin
                        if (b == qcsv_pkg::CH_CR) begin
                            mode = qcsv_pkg::MODE_SKIP;
                        end else if (b == qcsv_pkg::CH_QUOTE) begin
                            mode = qcsv_pkg::MODE_QUOTE;
                        end else if (b == qcsv_pkg::CH_COMMA) begin
                            mode = qcsv_pkg::MODE_START;
                            if (prev != qcsv_pkg::MODE_CLOSED) begin
                                r.field_end = 1'b1;
                                has         = 1'b1;
                            end
                        end
                        // stray unquoted bytes leave the mode alone
                    end
                endcase
            end
            if (has)
                pending = {pending, r};
            n_bytes++;
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            n_fail++;
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        endfunction

        function void check_result(qcsv_pkg::t_result got);
            qcsv_pkg::t_result want;
            if (pending.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected beat: expected none, got 0x%0h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.char_value !== want.char_value)
                flag("char_value", want.char_value, got.char_value);
            if (got.char_valid !== want.char_valid)
                flag("char_valid", 8'(want.char_valid), 8'(got.char_valid));
            if (got.field_end !== want.field_end)
                flag("field_end", 8'(want.field_end), 8'(got.field_end));
            if (got.row_end !== want.row_end)
                flag("row_end", 8'(want.row_end), 8'(got.row_end));
            if (got.quote_error !== want.quote_error)
                flag("quote_error", 8'(want.quote_error), 8'(got.quote_error));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;

    qcsv_byte_if in_if ();
    qcsv_res_if  out_if ();

    csv_scoreboard sb;

    quoted_csv_field_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("quoted_csv_field_parser_core verification failed");
        $finish;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    // input and output beats in one place so the prediction lands first
    always @(posedge i_clk) begin
        qcsv_pkg::t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_byte(in_if.byte_in);
            if (out_if.valid && out_if.ready) begin
                got.char_value  = out_if.char_value;
                got.char_valid  = out_if.char_valid;
                got.field_end   = out_if.field_end;
                got.row_end     = out_if.row_end;
                got.quote_error = out_if.quote_error;
                sb.check_result(got);
            end
        end
    end

    // result side back-pressure
    initial begin
        int g;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            g = pick_gap();
            if (g > 0) begin
                out_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.byte_in <= b;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_content();
        int          r;
        logic [7:0]  c;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            send_byte(qcsv_pkg::CH_BSLASH);
            case ($urandom_range(0, 4))
                0:       c = qcsv_pkg::CH_N;
                1:       c = qcsv_pkg::CH_R;
                2:       c = qcsv_pkg::CH_QUOTE;
                3:       c = qcsv_pkg::CH_BSLASH;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_byte(c);
        end else begin
            do begin
                c = (r == 2) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
            end while (c == qcsv_pkg::CH_NL || c == qcsv_pkg::CH_QUOTE ||
                       c == qcsv_pkg::CH_BSLASH);
            send_byte(c);
        end
    endtask

    task automatic send_noise(input bit biased);
        logic [7:0] c;
        if (!biased) begin
            c = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 7))
                0:       c = qcsv_pkg::CH_NL;
                1:       c = qcsv_pkg::CH_CR;
                2:       c = qcsv_pkg::CH_QUOTE;
                3:       c = qcsv_pkg::CH_COMMA;
                4:       c = qcsv_pkg::CH_BSLASH;
                5:       c = qcsv_pkg::CH_N;
                6:       c = qcsv_pkg::CH_R;
                default: c = 8'($urandom_range(0, 255));
            endcase
        end
        send_byte(c);
    endtask

    task automatic send_row();
        int kind;
        int nf;
        int len;
        kind    = $urandom_range(0, 9);
        no_idle = ($urandom_range(0, 3) == 0);
        if (kind < 7) begin
            nf = $urandom_range(0, 4);
            for (int k = 0; k < nf; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_byte(qcsv_pkg::CH_COMMA);
                end else begin
                    send_byte(qcsv_pkg::CH_QUOTE);
                    len = $urandom_range(0, 6);
                    for (int j = 0; j < len; j++)
                        send_content();
                    send_byte(qcsv_pkg::CH_QUOTE);
                    if (k < nf - 1 || $urandom_range(0, 3) == 0)
                        send_byte(qcsv_pkg::CH_COMMA);
                end
            end
            if ($urandom_range(0, 7) == 0)
                send_noise(1'b0);
            if ($urandom_range(0, 4) == 0) begin
                send_byte(qcsv_pkg::CH_CR);
                len = $urandom_range(0, 3);
                for (int j = 0; j < len; j++)
                    send_noise(1'b1);
            end
            send_byte(qcsv_pkg::CH_NL);
        end else if (kind == 7) begin
            // unterminated quote
            send_byte(qcsv_pkg::CH_QUOTE);
            len = $urandom_range(0, 4);
            for (int j = 0; j < len; j++)
                send_content();
            if ($urandom_range(0, 1) == 1)
                send_byte(qcsv_pkg::CH_BSLASH);
            send_byte(qcsv_pkg::CH_NL);
        end else begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++)
                send_noise(kind == 9);
        end
    endtask

    initial begin
        logic [7:0] directed[$];
        sb = new();
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.byte_in <= '0;
        no_idle        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank line, empty field, quoted field with extremes and every escape,
        // silent comma, stray byte then CR skip, newline after backslash and in quotes
        directed = {qcsv_pkg::CH_NL, qcsv_pkg::CH_COMMA, qcsv_pkg::CH_QUOTE, 8'd0, 8'd255,
                    qcsv_pkg::CH_BSLASH, qcsv_pkg::CH_N, qcsv_pkg::CH_BSLASH,
                    qcsv_pkg::CH_R, qcsv_pkg::CH_BSLASH, qcsv_pkg::CH_QUOTE,
                    qcsv_pkg::CH_BSLASH, qcsv_pkg::CH_BSLASH, qcsv_pkg::CH_BSLASH,
                    8'd65, qcsv_pkg::CH_QUOTE, qcsv_pkg::CH_COMMA, qcsv_pkg::CH_NL,
                    8'd120, qcsv_pkg::CH_CR, qcsv_pkg::CH_QUOTE, qcsv_pkg::CH_NL,
                    qcsv_pkg::CH_QUOTE, qcsv_pkg::CH_BSLASH, qcsv_pkg::CH_NL,
                    qcsv_pkg::CH_QUOTE, qcsv_pkg::CH_NL};
        foreach (directed[i])
            send_byte(directed[i]);

        while (sb.n_bytes < 550)
            send_row();
        send_byte(qcsv_pkg::CH_NL);
        in_if.valid <= 1'b0;
        no_idle      = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.n_fail == 0 && sb.pending.size() == 0)
            $display("quoted_csv_field_parser_core verification clean");
        else
            $display("quoted_csv_field_parser_core verification failed");
        $finish;
    end

endmodule

[quoted_csv_field_parser_core.f]
hw/rtl/qcsv_pkg.sv
hw/rtl/qcsv_if.sv
hw/rtl/qcsv_step.sv
hw/rtl/quoted_csv_field_parser_core.sv
dv/tb_quoted_csv_field_parser_core.sv
